// ===== design/sdf_pkg.sv =====
// Shared types and constants for the signed decimal field formatter.
`default_nettype none
package sdf_pkg;

    localparam int VALUE_W  = 32;
    localparam int FIELD_W  = 6;
    localparam int DIGITS   = 10;
    localparam int BCD_W    = 4 * DIGITS;
    localparam int CNT_W    = 5;   // counts the 32 conversion steps
    localparam int DIDX_W   = 4;
    localparam int CHAR_W   = 8;
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 8;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_CONV,
        FR_CALC
    } front_state_t;

    typedef enum logic {
        BK_IDLE,
        BK_EMIT
    } back_state_t;

    typedef logic [DIGITS-1:0][3:0] bcd_t;

    // One formatted field, reduced to segment boundaries on a position count.
    typedef struct packed {
        bcd_t               digits;   // least significant digit in entry 0
        logic [CHAR_W-1:0]  sign_ch;
        logic [FIELD_W-1:0] b_pre;    // end of leading spaces
        logic [FIELD_W-1:0] b_sign;   // end of sign
        logic [FIELD_W-1:0] b_zero;   // end of leading zeros
        logic [FIELD_W-1:0] b_digit;  // end of digits
        logic [FIELD_W-1:0] last_pos; // position of final character
    } desc_t;

endpackage
`default_nettype wire

// ===== design/signed_decimal_field_formatter.sv =====
// Top level of the signed decimal field formatter (printf %d style).
// Usage:
//   The input stream carries one number and its format per word; the
//   output stream returns the ASCII characters of the formatted field,
//   one character per word, with m_tlast on the final character.
//   Field order: padding spaces, sign, leading zeros, digits, trailing
//   spaces (left-justify), or sign, zero padding, digits (zero-pad).
// Timing:
//   The front end takes a word, then runs a 32-step shift-and-add-3
//   binary to BCD conversion, one bit per cycle, and a layout step;
//   it takes no new word until the field it holds has been pushed.
//   A two-entry descriptor queue sits between front and back, so a new
//   number is converted while the previous field is still being sent.
//   The back end loads a descriptor and then sends one character per
//   cycle while the output is not stalled.
// Reset: aresetn clears the control state; queue and output are empty.
// Stall: with m_tready low the output register holds its word; the back
//   end stops, the queue fills, and then s_tready stays low.
`default_nettype none
module signed_decimal_field_formatter #(
    parameter int MAX_WIDTH = 63
) (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire                           s_tvalid,
    output logic                          s_tready,
    // [31:0] value, [37:32] field_width, [43:38] min_digits,
    // [44] left_justify, [45] zero_pad, [46] force_plus, [47] space_sign
    input  wire [sdf_pkg::S_DATA_W-1:0]   s_tdata,
    output logic                          m_tvalid,
    input  wire                           m_tready,
    // [7:0] character
    output logic [sdf_pkg::M_DATA_W-1:0]  m_tdata,
    output logic                          m_tlast
);
    import sdf_pkg::*;

    logic   push, full, pop, empty;
    desc_t  push_data, pop_data;

    sdf_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .push      (push),
        .full      (full),
        .push_data (push_data)
    );

    sdf_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .empty     (empty),
        .pop_data  (pop_data)
    );

    sdf_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .empty     (empty),
        .pop_data  (pop_data),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule
`default_nettype wire

// ===== design/sdf_front.sv =====
// Front end: accepts a word, converts the magnitude to BCD and builds the field layout.
`default_nettype none
module sdf_front #(
    parameter int MAX_WIDTH = 63
) (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire                           s_tvalid,
    output logic                          s_tready,
    input  wire [sdf_pkg::S_DATA_W-1:0]   s_tdata,
    output logic                          push,
    input  wire                           full,
    output sdf_pkg::desc_t                push_data
);
    import sdf_pkg::*;

    localparam logic [FIELD_W-1:0] MAXW  = FIELD_W'(MAX_WIDTH);
    localparam logic [FIELD_W-1:0] MAXP  = FIELD_W'(MAX_WIDTH - 1);

    front_state_t          state_reg, state_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [VALUE_W-1:0]    mag_reg, mag_next;
    bcd_t                  bcd_reg, bcd_next;
    logic [FIELD_W-1:0]    width_reg, width_next;
    logic [FIELD_W-1:0]    prec_reg, prec_next;
    logic                  ljust_reg, ljust_next;
    logic                  zfill_reg, zfill_next;
    logic                  has_sign_reg, has_sign_next;
    logic [CHAR_W-1:0]     sign_reg, sign_next;

    logic [VALUE_W-1:0]    raw;
    logic                  neg;
    logic [FIELD_W-1:0]    w_in, p_in;
    bcd_t                  adj;
    logic [DIDX_W-1:0]     nd;
    logic [FIELD_W:0]      nz, body, pad, pre, zeros, post;
    logic [FIELD_W:0]      b1, b2, b3, b4, lp;

    assign raw = s_tdata[31:0];
    assign neg = raw[VALUE_W-1];
    assign w_in = s_tdata[37:32];
    assign p_in = s_tdata[43:38];
    assign s_tready = (state_reg == FR_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FR_IDLE;
        end else begin
            state_reg <= state_next;
        end
        cnt_reg      <= cnt_next;
        mag_reg      <= mag_next;
        bcd_reg      <= bcd_next;
        width_reg    <= width_next;
        prec_reg     <= prec_next;
        ljust_reg    <= ljust_next;
        zfill_reg    <= zfill_next;
        has_sign_reg <= has_sign_next;
        sign_reg     <= sign_next;
    end

    // add-3 correction ahead of each shift
    always_comb begin
        for (int i = 0; i < DIGITS; i++) begin
            adj[i] = (bcd_reg[i] >= 4'd5) ? bcd_reg[i] + 4'd3 : bcd_reg[i];
        end
    end

    // layout of the field from the converted digits
    always_comb begin
        nd = DIDX_W'(1);
        for (int i = 1; i < DIGITS; i++) begin
            if (bcd_reg[i] != 4'd0) begin
                nd = DIDX_W'(i + 1);
            end
        end
        nz   = (prec_reg > FIELD_W'(nd)) ? {1'b0, prec_reg} - (FIELD_W+1)'(nd) : '0;
        body = (FIELD_W+1)'(has_sign_reg) + (FIELD_W+1)'(nd) + nz;
        pad  = ({1'b0, width_reg} > body) ? {1'b0, width_reg} - body : '0;
        if (ljust_reg) begin
            pre = '0;  zeros = nz;  post = pad;
        end else if (zfill_reg) begin
            pre = '0;  zeros = pad; post = '0;
        end else begin
            pre = pad; zeros = nz;  post = '0;
        end
        b1 = pre;
        b2 = b1 + (FIELD_W+1)'(has_sign_reg);
        b3 = b2 + zeros;
        b4 = b3 + (FIELD_W+1)'(nd);
        lp = b4 + post - (FIELD_W+1)'(1);
        push_data.digits   = bcd_reg;
        push_data.sign_ch  = sign_reg;
        push_data.b_pre    = b1[FIELD_W-1:0];
        push_data.b_sign   = b2[FIELD_W-1:0];
        push_data.b_zero   = b3[FIELD_W-1:0];
        push_data.b_digit  = b4[FIELD_W-1:0];
        push_data.last_pos = lp[FIELD_W-1:0];
    end

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        mag_next      = mag_reg;
        bcd_next      = bcd_reg;
        width_next    = width_reg;
        prec_next     = prec_reg;
        ljust_next    = ljust_reg;
        zfill_next    = zfill_reg;
        has_sign_next = has_sign_reg;
        sign_next     = sign_reg;
        push          = 1'b0;
        case (state_reg)
            FR_IDLE: begin
                if (s_tvalid) begin
                    mag_next      = neg ? (~raw + 32'd1) : raw;
                    bcd_next      = '0;
                    cnt_next      = '0;
                    width_next    = (w_in > MAXW) ? MAXW : w_in;
                    prec_next     = (p_in > MAXP) ? MAXP : p_in;
                    ljust_next    = s_tdata[44];
                    zfill_next    = s_tdata[45] && (p_in == '0);
                    has_sign_next = neg || s_tdata[46] || s_tdata[47];
                    sign_next     = neg ? CH_MINUS : (s_tdata[46] ? CH_PLUS : CH_SPACE);
                    state_next    = FR_CONV;
                end
            end
            FR_CONV: begin
                {bcd_next, mag_next} = {adj, mag_reg} << 1;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == '1) begin
                    state_next = FR_CALC;
                end
            end
            FR_CALC: begin
                if (!full) begin
                    push       = 1'b1;
                    state_next = FR_IDLE;
                end
            end
            default: begin
                state_next = FR_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== design/sdf_queue.sv =====
// Two-entry queue of field descriptors between front and back.
`default_nettype none
module sdf_queue (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   push,
    input  wire sdf_pkg::desc_t   push_data,
    output logic                  full,
    input  wire                   pop,
    output logic                  empty,
    output sdf_pkg::desc_t        pop_data
);
    import sdf_pkg::*;

    desc_t        mem_reg [2];
    logic         wr_ptr_reg, wr_ptr_next;
    logic         rd_ptr_reg, rd_ptr_next;
    logic [1:0]   count_reg, count_next;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

// ===== design/sdf_back.sv =====
// Back end: walks a field descriptor and sends one character per word.
`default_nettype none
module sdf_back (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire                           empty,
    input  wire sdf_pkg::desc_t           pop_data,
    output logic                          pop,
    output logic                          m_tvalid,
    input  wire                           m_tready,
    output logic [sdf_pkg::M_DATA_W-1:0]  m_tdata,
    output logic                          m_tlast
);
    import sdf_pkg::*;

    back_state_t         state_reg, state_next;
    desc_t               desc_reg, desc_next;
    logic [FIELD_W-1:0]  pos_reg, pos_next;
    logic                valid_reg, valid_next;
    logic [CHAR_W-1:0]   char_reg, char_next;
    logic                last_reg, last_next;

    logic [FIELD_W-1:0]  didx_full;
    logic [DIDX_W-1:0]   didx;
    logic [3:0]          digit;
    logic [CHAR_W-1:0]   ch;
    logic                out_free;

    assign m_tvalid = valid_reg;
    assign m_tdata  = char_reg;
    assign m_tlast  = last_reg;
    assign out_free = !valid_reg || m_tready;

    assign didx_full = desc_reg.b_digit - FIELD_W'(1) - pos_reg;
    assign didx      = didx_full[DIDX_W-1:0];
    assign digit     = (didx < DIDX_W'(DIGITS)) ? desc_reg.digits[didx] : 4'd0;

    always_comb begin
        if (pos_reg < desc_reg.b_pre) begin
            ch = CH_SPACE;
        end else if (pos_reg < desc_reg.b_sign) begin
            ch = desc_reg.sign_ch;
        end else if (pos_reg < desc_reg.b_zero) begin
            ch = CH_ZERO;
        end else if (pos_reg < desc_reg.b_digit) begin
            ch = CH_ZERO | {4'd0, digit};
        end else begin
            ch = CH_SPACE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
        desc_reg <= desc_next;
        pos_reg  <= pos_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    always_comb begin
        state_next = state_reg;
        desc_next  = desc_reg;
        pos_next   = pos_reg;
        char_next  = char_reg;
        last_next  = last_reg;
        valid_next = valid_reg && !m_tready;
        pop        = 1'b0;
        case (state_reg)
            BK_IDLE: begin
                if (!empty) begin
                    pop        = 1'b1;
                    desc_next  = pop_data;
                    pos_next   = '0;
                    state_next = BK_EMIT;
                end
            end
            BK_EMIT: begin
                if (out_free) begin
                    valid_next = 1'b1;
                    char_next  = ch;
                    last_next  = (pos_reg == desc_reg.last_pos);
                    if (pos_reg == desc_reg.last_pos) begin
                        state_next = BK_IDLE;
                    end else begin
                        pos_next = pos_reg + FIELD_W'(1);
                    end
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire
